// ----- design/skt_pkg.sv -----
// shared types, sizes and codes for the sorted key table
// no dependencies; imported by skt_cell and sorted_key_table_with_delete_guard
package skt_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_W        = 64;
    localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W       = 6;
    localparam int STATUS_W     = 3;
    localparam int REQ_W        = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_KEY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TABLE_EMPTY = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IN_USE      = 3'd6;

    // one table record
    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    in_use;
    } entry_t;

    // per-cycle commands broadcast to every cell, already qualified
    typedef struct packed {
        logic ins;
        logic upd;
        logic del;
    } cell_ctl_t;

    // compare flags a cell reports back
    typedef struct packed {
        logic eq;
        logic gt;
        logic ins_here;
    } cell_flags_t;

endpackage

// ----- design/skt_cell.sv -----
// one slot of the sorted table: holds a record, compares it against the
// incoming key and shifts with its neighbors; uses skt_pkg
module skt_cell (
    input  logic                 clk,
    input  logic                 cap,
    input  logic [63:0]          cmp_key,
    input  skt_pkg::entry_t      new_ent,
    input  skt_pkg::cell_ctl_t   ctl,
    input  logic                 occ_self,
    input  logic                 occ_prev,
    input  logic                 gt_prev,
    input  skt_pkg::entry_t      left_ent,
    input  skt_pkg::entry_t      right_ent,
    output skt_pkg::entry_t      ent,
    output skt_pkg::cell_flags_t flags
);
    import skt_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   eq_reg;
    logic   gt_reg;
    logic   ins_here;

    // compare the incoming key against the stored one when a transaction is taken
    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            eq_reg <= occ_self && (ent_reg.key == cmp_key);
            gt_reg <= occ_self && (ent_reg.key > cmp_key);
        end
    end

    // new record lands here when the left neighbor is not larger and this cell
    // is either the first larger one or the first free one
    assign ins_here = !gt_prev && (gt_reg || (occ_prev && !occ_self));

    // record update: shift up, shift down, overwrite or hold
    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.ins)
        begin
            if (gt_prev)
            begin
                ent_next = left_ent;
            end
            else if (ins_here)
            begin
                ent_next = new_ent;
            end
        end
        if (ctl.upd && eq_reg)
        begin
            ent_next.payload = new_ent.payload;
            ent_next.in_use  = new_ent.in_use;
        end
        if (ctl.del && (eq_reg || gt_reg))
        begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent            = ent_reg;
    assign flags.eq       = eq_reg;
    assign flags.gt       = gt_reg;
    assign flags.ins_here = ins_here;

endmodule

// ----- design/sorted_key_table_with_delete_guard.sv -----
// top level of the sorted key table: request control, result register and
// the row of skt_cell slots; uses skt_pkg and skt_cell
//
// The table keeps up to 64 records sorted by unsigned 64-bit key in a row of
// cells, one record per cell. In the cycle a transaction is accepted, every
// cell compares its key with the request key and registers the flags. In
// S_EXEC those flags decide the result, which goes into the output register
// while the cells shift their records up (insert) or down (delete) by one
// place in that same edge. in_stall is high in S_EXEC, which lasts while a
// finished result still waits in the output register, so a new request is
// accepted only after the one in flight has completed. No clearing pass runs
// after reset; record slots are only read below the entry count.
module sorted_key_table_with_delete_guard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] key,
    input  logic [31:0] payload,
    input  logic        in_use,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [5:0]  slot,
    output logic [31:0] found_payload
);
    import skt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [REQ_W-1:0]        req_reg;
    entry_t                  new_ent_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       slot_next;
    logic [31:0]             fpay_reg;
    logic [31:0]             fpay_next;

    logic                    in_acc;
    logic                    out_free;
    logic                    done;
    cell_ctl_t               ctl;
    cell_ctl_t               ctl_pend;

    entry_t                  ents  [MAX_ENTRIES];
    cell_flags_t             flags [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  occ;
    logic [MAX_ENTRIES-1:0]  eq_vec;
    logic [MAX_ENTRIES-1:0]  ins_vec;

    logic                    any_eq;
    logic                    hit_use;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        ins_idx;
    logic [PAYLOAD_BITS-1:0] hit_pay;
    logic                    cnt_zero;
    logic                    cnt_full;

    // one-hot to index
    function automatic logic [IDX_W-1:0] enc(input logic [MAX_ENTRIES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (v[i])
            begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

    // handshake
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign done     = (state_reg == S_EXEC) && out_free;

    // occupancy thermometer from the entry count
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            occ[i]     = (CNT_W'(i) < count_reg);
            eq_vec[i]  = flags[i].eq;
            ins_vec[i] = flags[i].ins_here;
        end
    end

    // row of cells
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic   occ_prev_w;
        logic   gt_prev_w;
        entry_t left_w;
        entry_t right_w;

        if (g == 0)
        begin : g_first
            assign occ_prev_w = 1'b1;
            assign gt_prev_w  = 1'b0;
            assign left_w     = new_ent_reg;
        end
        else
        begin : g_mid
            assign occ_prev_w = occ[g-1];
            assign gt_prev_w  = flags[g-1].gt;
            assign left_w     = ents[g-1];
        end

        if (g == MAX_ENTRIES - 1)
        begin : g_last
            assign right_w = ents[g];
        end
        else
        begin : g_inner
            assign right_w = ents[g+1];
        end

        skt_cell u_cell (
            .clk       (clk),
            .cap       (in_acc),
            .cmp_key   (key),
            .new_ent   (new_ent_reg),
            .ctl       (ctl),
            .occ_self  (occ[g]),
            .occ_prev  (occ_prev_w),
            .gt_prev   (gt_prev_w),
            .left_ent  (left_w),
            .right_ent (right_w),
            .ent       (ents[g]),
            .flags     (flags[g])
        );
    end

    // hit reduction over the registered compare flags
    always_comb
    begin
        hit_use = 1'b0;
        hit_pay = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (eq_vec[i])
            begin
                hit_use = hit_use | ents[i].in_use;
                hit_pay = hit_pay | ents[i].payload;
            end
        end
    end

    assign any_eq   = |eq_vec;
    assign hit_idx  = enc(eq_vec);
    assign ins_idx  = enc(ins_vec);
    assign cnt_zero = (count_reg == '0);
    assign cnt_full = (count_reg == CNT_W'(MAX_ENTRIES));

    // result and table command for the request in flight
    always_comb
    begin
        status_next = ST_OK;
        slot_next   = '0;
        fpay_next   = '0;
        ctl_pend    = '0;
        count_next  = count_reg;
        unique case (req_reg)
            REQ_INSERT:
            begin
                if (new_ent_reg.key == '0)
                begin
                    status_next = ST_EMPTY_KEY;
                end
                else if (cnt_full)
                begin
                    status_next = ST_FULL;
                end
                else if (any_eq)
                begin
                    status_next = ST_DUP;
                end
                else
                begin
                    slot_next    = SLOT_W'(ins_idx);
                    ctl_pend.ins = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            REQ_UPDATE:
            begin
                if (cnt_zero)
                begin
                    status_next = ST_TABLE_EMPTY;
                end
                else if (!any_eq)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    slot_next    = SLOT_W'(hit_idx);
                    ctl_pend.upd = 1'b1;
                end
            end
            REQ_DELETE:
            begin
                if (cnt_zero)
                begin
                    status_next = ST_TABLE_EMPTY;
                end
                else if (!any_eq)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (hit_use)
                begin
                    status_next = ST_IN_USE;
                    slot_next   = SLOT_W'(hit_idx);
                end
                else
                begin
                    slot_next    = SLOT_W'(hit_idx);
                    ctl_pend.del = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            REQ_SEARCH:
            begin
                if (any_eq)
                begin
                    slot_next = SLOT_W'(hit_idx);
                    fpay_next = 32'(hit_pay);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    // commands reach the cells only on the completing edge
    assign ctl = done ? ctl_pend : '0;

    // control state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg             <= req_type;
            new_ent_reg.key     <= key;
            new_ent_reg.payload <= PAYLOAD_BITS'(payload);
            new_ent_reg.in_use  <= in_use;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            fpay_reg   <= fpay_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign found_payload = fpay_reg;

endmodule
